// File: design/frame_ring_scoreboard_assert.svh
`ifndef FRAME_RING_SCOREBOARD_ASSERT_SVH
`define FRAME_RING_SCOREBOARD_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define FSB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define FSB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset
`define FSB_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/fsb_pkg.sv
package fsb_pkg;

   typedef enum logic [1:0] {
      OP_PRODUCER_DONE  = 2'd0,
      OP_CONSUMER_DONE  = 2'd1,
      OP_PRODUCER_QUERY = 2'd2,
      OP_CONSUMER_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } back_state_type;

   localparam logic [1:0] CSR_PRODUCER_MASK = 2'd0;
   localparam logic [1:0] CSR_CONSUMER_MASK = 2'd1;
   localparam logic [1:0] CSR_FRAMES_IN_USE = 2'd2;

   localparam int OP_W = 2;

   localparam int RSP_READY_BIT   = 0;
   localparam int RSP_FULL_BIT    = 1;
   localparam int RSP_FREED_BIT   = 2;
   localparam int RSP_DROPPED_BIT = 3;
   localparam int RSP_ERROR_BIT   = 4;
   localparam int RSP_COUNT_LSB   = 5;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      op_type op;
      logic   err;
   } item_ctl_type;

   localparam int CTL_W = $bits(item_ctl_type);

endpackage

// File: design/frame_ring_scoreboard.sv
// Ownership scoreboard for a ring of MAX_FRAMES frames shared by up to PRODUCER_SLOTS
// producers and CONSUMER_SLOTS consumers. Each request transaction carries an op
// (producer done, consumer done, producer write query, consumer read query), a frame
// and an agent slot, and yields exactly one response transaction with the query
// answer, the became_full / freed / dropped / error flags and the count of full
// frames. Requests are checked for range and registration on entry and wait in a
// four-deep queue; the execution side then takes one transaction at a time: it reads
// the frame's state memory, then updates and writes it back once the registered
// response stage is free. That stage lets the next request be popped and read while
// a response waits. After reset the block clears the frame state memory, with
// req_tready low; configuration writes are taken during that time. Write registers
// only while no transaction is in flight.
module frame_ring_scoreboard #(
   parameter int MAX_FRAMES     = 64,
   parameter int PRODUCER_SLOTS = 8,
   parameter int CONSUMER_SLOTS = 8
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // op, frame, agent (from bit 0 up), zero padded to whole bytes
   input  logic [((fsb_pkg::OP_W + $clog2(MAX_FRAMES)
                   + (((PRODUCER_SLOTS > CONSUMER_SLOTS) ? PRODUCER_SLOTS : CONSUMER_SLOTS) > 1
                      ? $clog2((PRODUCER_SLOTS > CONSUMER_SLOTS) ? PRODUCER_SLOTS
                                                                  : CONSUMER_SLOTS)
                      : 1) + 7) / 8) * 8 - 1:0] req_tdata,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // ready_res, became_full, freed, dropped, error, full_count (from bit 0 up)
   output logic [((fsb_pkg::RSP_COUNT_LSB + $clog2(MAX_FRAMES + 1) + 7) / 8) * 8 - 1:0]
                rsp_tdata,

   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [((PRODUCER_SLOTS > CONSUMER_SLOTS ? PRODUCER_SLOTS : CONSUMER_SLOTS)
                  > $clog2(MAX_FRAMES + 1)
                  ? (PRODUCER_SLOTS > CONSUMER_SLOTS ? PRODUCER_SLOTS : CONSUMER_SLOTS)
                  : $clog2(MAX_FRAMES + 1)) - 1:0] csr_wdata
);

   localparam int FRAME_W  = $clog2(MAX_FRAMES);
   localparam int COUNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_MAX = (PRODUCER_SLOTS > CONSUMER_SLOTS) ? PRODUCER_SLOTS
                                                               : CONSUMER_SLOTS;
   localparam int REQ_W    = $bits(req_tdata);
   localparam int RSP_W    = $bits(rsp_tdata);
   localparam int ENTRY_W  = fsb_pkg::CTL_W + FRAME_W + SLOT_MAX;

   logic [PRODUCER_SLOTS-1:0] producer_mask_ff;
   logic [CONSUMER_SLOTS-1:0] consumer_mask_ff;
   logic [COUNT_W-1:0]        frames_in_use_ff;

   logic               clearing;
   logic               queue_full;
   logic               queue_empty;
   logic               push;
   logic               pop;
   logic [ENTRY_W-1:0] push_data;
   logic [ENTRY_W-1:0] pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         producer_mask_ff <= '0;
         consumer_mask_ff <= '0;
         frames_in_use_ff <= COUNT_W'(MAX_FRAMES);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fsb_pkg::CSR_PRODUCER_MASK: producer_mask_ff <= csr_wdata[PRODUCER_SLOTS-1:0];
            fsb_pkg::CSR_CONSUMER_MASK: consumer_mask_ff <= csr_wdata[CONSUMER_SLOTS-1:0];
            fsb_pkg::CSR_FRAMES_IN_USE: frames_in_use_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
               producer_mask_ff <= producer_mask_ff;
            end
         endcase
      end
   end

   fsb_front #(
      .MAX_FRAMES     (MAX_FRAMES),
      .PRODUCER_SLOTS (PRODUCER_SLOTS),
      .CONSUMER_SLOTS (CONSUMER_SLOTS),
      .REQ_W          (REQ_W),
      .ENTRY_W        (ENTRY_W)
   ) u_fsb_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .clearing      (clearing),
      .queue_full    (queue_full),
      .producer_mask (producer_mask_ff),
      .consumer_mask (consumer_mask_ff),
      .frames_in_use (frames_in_use_ff),
      .push          (push),
      .push_data     (push_data)
   );

   fsb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (fsb_pkg::QUEUE_DEPTH)
   ) u_fsb_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   fsb_back #(
      .MAX_FRAMES     (MAX_FRAMES),
      .PRODUCER_SLOTS (PRODUCER_SLOTS),
      .CONSUMER_SLOTS (CONSUMER_SLOTS),
      .ENTRY_W        (ENTRY_W),
      .RSP_W          (RSP_W)
   ) u_fsb_back (
      .clock         (clock),
      .reset         (reset),
      .producer_mask (producer_mask_ff),
      .consumer_mask (consumer_mask_ff),
      .pop_data      (pop_data),
      .empty         (queue_empty),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

// File: design/fsb_ram.sv
module fsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fsb_front.sv
module fsb_front #(
   parameter int MAX_FRAMES     = 64,
   parameter int PRODUCER_SLOTS = 8,
   parameter int CONSUMER_SLOTS = 8,
   parameter int REQ_W          = 16,
   parameter int ENTRY_W        = 17
) (
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [REQ_W-1:0]                       req_tdata,
   input  logic                                   clearing,
   input  logic                                   queue_full,
   input  logic [PRODUCER_SLOTS-1:0]              producer_mask,
   input  logic [CONSUMER_SLOTS-1:0]              consumer_mask,
   input  logic [$clog2(MAX_FRAMES+1)-1:0]        frames_in_use,
   output logic                                   push,
   output logic [ENTRY_W-1:0]                     push_data
);

   localparam int FRAME_W  = $clog2(MAX_FRAMES);
   localparam int COUNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_MAX = (PRODUCER_SLOTS > CONSUMER_SLOTS) ? PRODUCER_SLOTS
                                                               : CONSUMER_SLOTS;
   localparam int AGENT_W  = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;

   fsb_pkg::op_type       op;
   logic [FRAME_W-1:0]    frame;
   logic [AGENT_W-1:0]    agent;
   logic [COUNT_W-1:0]    limit;
   logic [SLOT_MAX-1:0]   agent_hot;
   logic                  range_err;
   logic                  prod_hit;
   logic                  cons_hit;
   logic                  is_prod;
   fsb_pkg::item_ctl_type ctl;

   assign op    = fsb_pkg::op_type'(req_tdata[fsb_pkg::OP_W-1:0]);
   assign frame = req_tdata[fsb_pkg::OP_W +: FRAME_W];
   assign agent = req_tdata[fsb_pkg::OP_W + FRAME_W +: AGENT_W];

   always_comb begin
      limit = (frames_in_use > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : frames_in_use;
      range_err = (COUNT_W'(frame) >= limit);
      for (int i = 0; i < SLOT_MAX; i++) begin
         agent_hot[i] = (agent == AGENT_W'(i));
      end
      prod_hit = |(producer_mask & agent_hot[PRODUCER_SLOTS-1:0]);
      cons_hit = |(consumer_mask & agent_hot[CONSUMER_SLOTS-1:0]);
      is_prod  = (op == fsb_pkg::OP_PRODUCER_DONE) || (op == fsb_pkg::OP_PRODUCER_QUERY);
      ctl.op   = op;
      ctl.err  = range_err || !(is_prod ? prod_hit : cons_hit);
   end

   assign req_tready = !clearing && !queue_full;
   assign push       = req_tvalid && req_tready;
   assign push_data  = {ctl, frame, agent_hot};

endmodule

// File: design/fsb_queue.sv
module fsb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// File: design/fsb_back.sv
module fsb_back #(
   parameter int MAX_FRAMES     = 64,
   parameter int PRODUCER_SLOTS = 8,
   parameter int CONSUMER_SLOTS = 8,
   parameter int ENTRY_W        = 17,
   parameter int RSP_W          = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [PRODUCER_SLOTS-1:0] producer_mask,
   input  logic [CONSUMER_SLOTS-1:0] consumer_mask,
   input  logic [ENTRY_W-1:0]        pop_data,
   input  logic                      empty,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata
);

   localparam int FRAME_W  = $clog2(MAX_FRAMES);
   localparam int COUNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_MAX = (PRODUCER_SLOTS > CONSUMER_SLOTS) ? PRODUCER_SLOTS
                                                               : CONSUMER_SLOTS;
   localparam int WORD_W   = 1 + PRODUCER_SLOTS + CONSUMER_SLOTS;
   localparam int RSP_BITS = fsb_pkg::RSP_COUNT_LSB + COUNT_W;

   fsb_pkg::back_state_type state_ff, state_in;
   fsb_pkg::item_ctl_type   cur_ctl_ff, head_ctl;
   logic [FRAME_W-1:0]      cur_frame_ff, head_frame;
   logic [SLOT_MAX-1:0]     cur_hot_ff, head_hot;
   logic [FRAME_W-1:0]      clear_addr_ff, clear_addr_in;
   logic [COUNT_W-1:0]      full_total_ff, full_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic                    ram_wr_en;
   logic [FRAME_W-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]       ram_wr_data;
   logic                    ram_rd_en;
   logic [WORD_W-1:0]       ram_rd_data;

   logic                          old_full, new_full;
   logic [PRODUCER_SLOTS-1:0]     old_pf, new_pf, pbit;
   logic [CONSUMER_SLOTS-1:0]     old_cf, new_cf, cbit;
   logic                          ready, full_ev, freed, drop, err, inc, dec;
   logic                          rsp_free, load_rsp;

   assign head_ctl   = fsb_pkg::item_ctl_type'(pop_data[ENTRY_W-1 -: fsb_pkg::CTL_W]);
   assign head_frame = pop_data[SLOT_MAX +: FRAME_W];
   assign head_hot   = pop_data[SLOT_MAX-1:0];

   fsb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_FRAMES)
   ) u_fsb_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_frame),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      old_full = ram_rd_data[WORD_W-1];
      old_pf   = ram_rd_data[CONSUMER_SLOTS +: PRODUCER_SLOTS];
      old_cf   = ram_rd_data[CONSUMER_SLOTS-1:0];
      pbit     = cur_hot_ff[PRODUCER_SLOTS-1:0];
      cbit     = cur_hot_ff[CONSUMER_SLOTS-1:0];
      new_full = old_full;
      new_pf   = old_pf;
      new_cf   = old_cf;
      ready    = 1'b0;
      full_ev  = 1'b0;
      freed    = 1'b0;
      drop     = 1'b0;
      err      = cur_ctl_ff.err;
      inc      = 1'b0;
      dec      = 1'b0;
      if (!cur_ctl_ff.err) begin
         unique case (cur_ctl_ff.op)
            fsb_pkg::OP_PRODUCER_DONE: begin
               if (|(old_pf & pbit)) begin
                  err = 1'b1;
               end else begin
                  new_pf = old_pf | pbit;
                  if ((producer_mask & ~new_pf) == '0) begin
                     new_pf  = '0;
                     full_ev = 1'b1;
                     if (!old_full) begin
                        new_full = 1'b1;
                        inc      = 1'b1;
                     end
                  end
                  if ((consumer_mask & ~old_cf) == '0) begin
                     if (new_full) begin
                        drop  = 1'b1;
                        freed = 1'b1;
                        dec   = 1'b1;
                     end
                     new_full = 1'b0;
                     new_cf   = '0;
                  end
               end
            end
            fsb_pkg::OP_CONSUMER_DONE: begin
               if (|(old_cf & cbit)) begin
                  err = 1'b1;
               end else begin
                  new_cf = old_cf | cbit;
                  if ((consumer_mask & ~new_cf) == '0) begin
                     dec      = old_full;
                     new_full = 1'b0;
                     new_cf   = '0;
                     freed    = 1'b1;
                  end
               end
            end
            fsb_pkg::OP_PRODUCER_QUERY: begin
               ready = !old_full && !(|(old_pf & pbit));
            end
            fsb_pkg::OP_CONSUMER_QUERY: begin
               ready = old_full && !(|(old_cf & cbit));
            end
            default: begin
               ready = 1'b0;
            end
         endcase
      end
      full_total_in = full_total_ff + COUNT_W'(inc) - COUNT_W'(dec);
      rsp_data_in = '0;
      rsp_data_in[fsb_pkg::RSP_READY_BIT]   = ready;
      rsp_data_in[fsb_pkg::RSP_FULL_BIT]    = full_ev;
      rsp_data_in[fsb_pkg::RSP_FREED_BIT]   = freed;
      rsp_data_in[fsb_pkg::RSP_DROPPED_BIT] = drop;
      rsp_data_in[fsb_pkg::RSP_ERROR_BIT]   = err;
      rsp_data_in[fsb_pkg::RSP_COUNT_LSB +: COUNT_W] = full_total_in;
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      pop           = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_frame_ff;
      ram_wr_data   = {new_full, new_pf, new_cf};
      load_rsp      = 1'b0;
      unique case (state_ff)
         fsb_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_addr_ff;
            ram_wr_data = '0;
            if (clear_addr_ff == FRAME_W'(MAX_FRAMES - 1)) begin
               state_in = fsb_pkg::ST_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + 1'b1;
            end
         end
         fsb_pkg::ST_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               ram_rd_en = 1'b1;
               state_in  = fsb_pkg::ST_EXEC;
            end
         end
         fsb_pkg::ST_EXEC: begin
            if (rsp_free) begin
               load_rsp  = 1'b1;
               ram_wr_en = !err;
               state_in  = fsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsb_pkg::ST_CLEAR;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsb_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         full_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (load_rsp) begin
            full_total_ff <= full_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ctl_ff   <= head_ctl;
         cur_frame_ff <= head_frame;
         cur_hot_ff   <= head_hot;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign clearing   = (state_ff == fsb_pkg::ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

// File: design/fsb_checker.sv
`include "frame_ring_scoreboard_assert.svh"

module fsb_checker #(
   parameter int MAX_FRAMES = 64,
   parameter int RSP_W      = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int COUNT_W = $clog2(MAX_FRAMES + 1);

   logic [COUNT_W-1:0] last_count_ff;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_take;
   logic               rsp_wait;
   logic               rsp_err;
   logic               rsp_drop;
   logic               drop_ok;

   assign rsp_count = rsp_tdata[fsb_pkg::RSP_COUNT_LSB +: COUNT_W];
   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign rsp_wait  = rsp_tvalid && !rsp_tready;
   assign rsp_err   = rsp_take && rsp_tdata[fsb_pkg::RSP_ERROR_BIT];
   assign rsp_drop  = rsp_tvalid && rsp_tdata[fsb_pkg::RSP_DROPPED_BIT];
   assign drop_ok   = rsp_tdata[fsb_pkg::RSP_FREED_BIT] && !rsp_tdata[fsb_pkg::RSP_ERROR_BIT]
                      && !rsp_tdata[fsb_pkg::RSP_READY_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_take) begin
         last_count_ff <= rsp_count;
      end
   end

   `FSB_ASSERT_NXT_ALWAYS(a_clear_after_reset, clock, reset, !req_tready,
      "request accepted during clearing pass")

   `FSB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait,
      $stable({rsp_tvalid, rsp_tdata}), "stalled response changed")

   `FSB_ASSERT_IMP(a_error_keeps_count, clock, reset, rsp_err,
      rsp_count == last_count_ff, "error response changed full count")

   `FSB_ASSERT_IMP(a_drop_frees, clock, reset, rsp_drop, drop_ok,
      "dropped frame not reported as freed")

endmodule

bind frame_ring_scoreboard fsb_checker #(
   .MAX_FRAMES (MAX_FRAMES),
   .RSP_W      (RSP_W)
) u_fsb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/frame_ring_tracker.sv
`timescale 1ns / 1ps

module frame_ring_tracker #(
   parameter int REQ_W = 16,
   parameter int RSP_W = 16,
   parameter int CSR_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               outstanding
);

   typedef struct packed {
      logic       ready_res;
      logic       became_full;
      logic       freed;
      logic       dropped;
      logic       error;
      logic [6:0] full_count;
   } frame_outcome_type;

   logic       slot_full [64];
   logic [7:0] producer_marks [64];
   logic [7:0] consumer_marks [64];
   logic [6:0] full_frames;
   logic [7:0] producer_mask_q;
   logic [7:0] consumer_mask_q;
   logic [6:0] frames_q;

   frame_outcome_type expected_outcomes[$];
   int                mismatch_total = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic void empty_slot(logic [5:0] f);
      if (slot_full[f]) begin
         slot_full[f] = 1'b0;
         full_frames  = full_frames - 7'd1;
      end
      consumer_marks[f] = '0;
   endfunction

   function automatic frame_outcome_type apply_request(fsb_pkg::op_type op, logic [5:0] f,
                                                       logic [2:0] a);
      frame_outcome_type r;
      logic [7:0]        agents;
      logic [7:0]        agent_bit;
      int unsigned       usable;
      r         = '0;
      usable    = (frames_q > 7'd64) ? 64 : frames_q;
      agents    = (op == fsb_pkg::OP_PRODUCER_DONE || op == fsb_pkg::OP_PRODUCER_QUERY)
                  ? producer_mask_q : consumer_mask_q;
      agent_bit = 8'd1 << a;
      if (f >= usable || (agents & agent_bit) == '0) begin
         r.error = 1'b1;
      end else begin
         case (op)
            fsb_pkg::OP_PRODUCER_DONE: begin
               if ((producer_marks[f] & agent_bit) != '0) begin
                  r.error = 1'b1;
               end else begin
                  producer_marks[f] |= agent_bit;
                  if ((producer_mask_q & ~producer_marks[f]) == '0) begin
                     producer_marks[f] = '0;
                     if (!slot_full[f]) begin
                        slot_full[f] = 1'b1;
                        full_frames  = full_frames + 7'd1;
                     end
                     r.became_full = 1'b1;
                  end
                  if ((consumer_mask_q & ~consumer_marks[f]) == '0) begin
                     if (slot_full[f]) begin
                        r.dropped = 1'b1;
                        r.freed   = 1'b1;
                     end
                     empty_slot(f);
                  end
               end
            end
            fsb_pkg::OP_CONSUMER_DONE: begin
               if ((consumer_marks[f] & agent_bit) != '0) begin
                  r.error = 1'b1;
               end else begin
                  consumer_marks[f] |= agent_bit;
                  if ((consumer_mask_q & ~consumer_marks[f]) == '0) begin
                     empty_slot(f);
                     r.freed = 1'b1;
                  end
               end
            end
            fsb_pkg::OP_PRODUCER_QUERY: begin
               r.ready_res = !slot_full[f] && (producer_marks[f] & agent_bit) == '0;
            end
            default: begin
               r.ready_res = slot_full[f] && (consumer_marks[f] & agent_bit) == '0;
            end
         endcase
      end
      r.full_count = full_frames;
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      frame_outcome_type want;
      if (reset) begin
         for (int i = 0; i < 64; i++) begin
            slot_full[i]      = 1'b0;
            producer_marks[i] = '0;
            consumer_marks[i] = '0;
         end
         full_frames     = '0;
         producer_mask_q = '0;
         consumer_mask_q = '0;
         frames_q        = 7'd64;
         expected_outcomes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               fsb_pkg::CSR_PRODUCER_MASK: producer_mask_q = csr_wdata[7:0];
               fsb_pkg::CSR_CONSUMER_MASK: consumer_mask_q = csr_wdata[7:0];
               fsb_pkg::CSR_FRAMES_IN_USE: frames_q = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_request(fsb_pkg::op_type'(req_tdata[1:0]),
                                                      req_tdata[7:2], req_tdata[10:8]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response transaction with nothing expected: %h", rsp_tdata);
               mismatch_total++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("ready_res", want.ready_res, rsp_tdata[fsb_pkg::RSP_READY_BIT]);
               check_field("became_full", want.became_full, rsp_tdata[fsb_pkg::RSP_FULL_BIT]);
               check_field("freed", want.freed, rsp_tdata[fsb_pkg::RSP_FREED_BIT]);
               check_field("dropped", want.dropped, rsp_tdata[fsb_pkg::RSP_DROPPED_BIT]);
               check_field("error", want.error, rsp_tdata[fsb_pkg::RSP_ERROR_BIT]);
               check_field("full_count", want.full_count,
                           rsp_tdata[fsb_pkg::RSP_COUNT_LSB +: 7]);
            end
         end
      end
      outstanding <= expected_outcomes.size();
      fail_count  <= mismatch_total;
   end

endmodule

// File: verif/frame_ring_scoreboard_test.sv
`timescale 1ns / 1ps

module frame_ring_scoreboard_test;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en  = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;

   int         fail_count;
   int         outstanding;
   int         items_sent   = 0;
   int         hold_request = 0;
   bit         gaps_on      = 1'b1;
   logic [7:0] cur_pmask;
   logic [7:0] cur_cmask;
   logic [6:0] cur_frames;

   frame_ring_scoreboard dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frame_ring_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("frame_ring_scoreboard_test: FAIL");
      $finish;
   end

   // response side: random backpressure, plus long hold-offs on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!gaps_on) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic send_req(fsb_pkg::op_type op, logic [5:0] frame_idx, logic [2:0] agent_idx);
      if (gaps_on) begin
         while ($urandom_range(99) < 23) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, agent_idx, frame_idx, op};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] pmask, logic [7:0] cmask, logic [6:0] nframes);
      cur_pmask  = pmask;
      cur_cmask  = cmask;
      cur_frames = nframes;
      csr_wr_en <= 1'b1;
      csr_index <= fsb_pkg::CSR_PRODUCER_MASK;
      csr_wdata <= pmask;
      @(posedge clock);
      csr_index <= fsb_pkg::CSR_CONSUMER_MASK;
      csr_wdata <= cmask;
      @(posedge clock);
      csr_index <= fsb_pkg::CSR_FRAMES_IN_USE;
      csr_wdata <= {1'b0, nframes};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mark every registered agent once, in a rotated order, skipping a few
   task automatic sweep_agents(logic [7:0] mask, fsb_pkg::op_type query_op,
                               fsb_pkg::op_type done_op, logic [5:0] f);
      int         start;
      bit         up;
      logic [2:0] a;
      start = $urandom_range(7);
      up    = 1'($urandom_range(1));
      for (int i = 0; i < 8; i++) begin
         a = up ? 3'(start + i) : 3'(start - i);
         if (mask[a] && $urandom_range(99) >= 5) begin
            if ($urandom_range(99) < 20) send_req(query_op, f, a);
            send_req(done_op, f, a);
         end
      end
   endtask

   task automatic random_phase(int count);
      int target;
      int usable;
      logic [5:0] f;
      target = items_sent + count;
      usable = (cur_frames > 7'd64) ? 64 : cur_frames;
      while (items_sent < target) begin
         if (usable != 0 && $urandom_range(99) < 75) begin
            f = 6'($urandom_range(usable - 1));
            sweep_agents(cur_pmask, fsb_pkg::OP_PRODUCER_QUERY, fsb_pkg::OP_PRODUCER_DONE, f);
            sweep_agents(cur_cmask, fsb_pkg::OP_CONSUMER_QUERY, fsb_pkg::OP_CONSUMER_DONE, f);
         end else begin
            send_req(fsb_pkg::op_type'($urandom_range(3)), 6'($urandom_range(63)),
                     3'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_config(8'h81, 8'h81, 7'd64);
      send_req(fsb_pkg::OP_PRODUCER_QUERY, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_QUERY, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd7);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd63, 3'd3);
      send_req(fsb_pkg::OP_CONSUMER_QUERY, 6'd0, 3'd7);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd0, 3'd7);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd0, 3'd7);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd7);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd5, 3'd0);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd9, 3'd0);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd9, 3'd7);
      send_req(fsb_pkg::OP_CONSUMER_QUERY, 6'd63, 3'd1);
      drain();

      // consumer bits of frame 5 survive the mask change
      set_config(8'h01, 8'h01, 7'd127);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd5, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd63, 3'd0);
      drain();

      set_config(8'h01, 8'h00, 7'd1);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_PRODUCER_DONE, 6'd1, 3'd0);
      send_req(fsb_pkg::OP_CONSUMER_QUERY, 6'd0, 3'd0);
      drain();

      set_config(8'h00, 8'hFF, 7'd0);
      send_req(fsb_pkg::OP_PRODUCER_QUERY, 6'd0, 3'd0);
      send_req(fsb_pkg::OP_CONSUMER_DONE, 6'd63, 3'd7);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_config(8'hFF, 8'hFF, 7'd64);
            1: set_config(8'h01, 8'h00, 7'd1);
            2: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                          7'($urandom_range(2, 16)));
            3: set_config(8'h80, 8'h80, 7'd8);
            4: set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 7'd64);
            5: set_config(8'hFF, 8'h00, 7'($urandom_range(1, 64)));
            6: set_config(8'($urandom_range(255)), 8'hFF, 7'd1);
            default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                7'($urandom_range(1, 64)));
         endcase
         if (phase == 0) hold_request = 300;
         gaps_on = (phase != 2);
         random_phase(65);
         drain();
      end

      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("frame_ring_scoreboard_test: PASS");
      end else begin
         $display("frame_ring_scoreboard_test: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/fsb_pkg.sv
design/fsb_ram.sv
design/fsb_front.sv
design/fsb_queue.sv
design/fsb_back.sv
design/frame_ring_scoreboard.sv
design/fsb_checker.sv
verif/frame_ring_tracker.sv
verif/frame_ring_scoreboard_test.sv
